/* hw/rtl/lr_pkg.sv */
package lr_pkg;

    localparam int COORD_W         = 6;
    localparam int CHAR_W          = 8;
    localparam int ERR_W           = COORD_W + 4;
    localparam int DEF_CANVAS_SIZE = 64;
    localparam int MAX_PIXELS      = 64;
    localparam int CNT_W           = $clog2(MAX_PIXELS);
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ye;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic               sx_pos;
        logic               sy_pos;
        logic [ERR_W-1:0]   err;
        logic [CHAR_W-1:0]  fill;
    } line_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

/* hw/rtl/lr_front.sv */
module lr_front #(
    parameter int CANVAS_SIZE = lr_pkg::DEF_CANVAS_SIZE
) (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [lr_pkg::COORD_W-1:0] s_start_x,
    input  logic [lr_pkg::COORD_W-1:0] s_start_y,
    input  logic [lr_pkg::COORD_W-1:0] s_end_x,
    input  logic [lr_pkg::COORD_W-1:0] s_end_y,
    input  logic [lr_pkg::CHAR_W-1:0]  s_fill_char,
    input  lr_pkg::queue_stat_t        q_stat,
    output logic                       q_push,
    output lr_pkg::line_cmd_t          q_cmd
);
    import lr_pkg::*;

    localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(CANVAS_SIZE - 1);

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
        return (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    logic [COORD_W-1:0] x0, y0, x1, y1;

    always_comb begin
        x0 = clamp(s_start_x);
        y0 = clamp(s_start_y);
        x1 = clamp(s_end_x);
        y1 = clamp(s_end_y);

        q_cmd.x      = x0;
        q_cmd.y      = y0;
        q_cmd.xe     = x1;
        q_cmd.ye     = y1;
        q_cmd.sx_pos = x0 < x1;
        q_cmd.sy_pos = y0 < y1;
        q_cmd.dx     = (x1 > x0) ? (x1 - x0) : (x0 - x1);
        q_cmd.dy     = (y1 > y0) ? (y1 - y0) : (y0 - y1);
        q_cmd.err    = ERR_W'(q_cmd.dx) - ERR_W'(q_cmd.dy);
        q_cmd.fill   = s_fill_char;
    end

    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready;

endmodule

/* hw/rtl/lr_queue.sv */
module lr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lr_pkg::line_cmd_t   push_cmd,
    input  logic                pop,
    output lr_pkg::line_cmd_t   head_cmd,
    output lr_pkg::queue_stat_t stat
);
    import lr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    line_cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        stat.full   = count_reg == CNT_QW'(QUEUE_DEPTH);
        stat.empty  = count_reg == '0;
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_QW'(do_push) - CNT_QW'(do_pop);
        head_cmd    = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hw/rtl/lr_walker.sv */
module lr_walker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lr_pkg::queue_stat_t        q_stat,
    input  lr_pkg::line_cmd_t          q_cmd,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lr_pkg::COORD_W-1:0] m_pixel_x,
    output logic [lr_pkg::COORD_W-1:0] m_pixel_y,
    output logic [lr_pkg::CHAR_W-1:0]  m_pixel_char,
    output logic                       m_last_pixel
);
    import lr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;
    localparam int   E2_W    = ERR_W + 1;

    logic               state_reg, state_next;
    line_cmd_t          cmd_reg, cmd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] px_reg, px_next;
    logic [COORD_W-1:0] py_reg, py_next;
    logic [CHAR_W-1:0]  pc_reg, pc_next;
    logic               pl_reg, pl_next;

    logic               adv, x_at, y_at, c1, c2, last;
    logic signed [E2_W-1:0] e2, dx_e, dy_n, err_sum;

    always_comb begin
        adv     = (state_reg == ST_WALK) && (!m_valid_reg || m_ready);
        e2      = {cmd_reg.err, 1'b0};
        dx_e    = $signed({{(E2_W-COORD_W){1'b0}}, cmd_reg.dx});
        dy_n    = -$signed({{(E2_W-COORD_W){1'b0}}, cmd_reg.dy});
        c1      = e2 >= dy_n;
        c2      = e2 <= dx_e;
        x_at    = cmd_reg.x == cmd_reg.xe;
        y_at    = cmd_reg.y == cmd_reg.ye;
        last    = (cnt_reg == CNT_W'(MAX_PIXELS - 1)) || (x_at && y_at)
                  || (c1 && x_at) || (c2 && y_at);
        err_sum = $signed({cmd_reg.err[ERR_W-1], cmd_reg.err})
                  + (c1 ? dy_n : '0) + (c2 ? dx_e : '0);

        state_next   = state_reg;
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pc_next      = pc_reg;
        pl_next      = pl_reg;
        q_pop        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    px_next      = cmd_reg.x;
                    py_next      = cmd_reg.y;
                    pc_next      = cmd_reg.fill;
                    pl_next      = last;
                    cnt_next     = cnt_reg + 1'b1;
                    cmd_next.err = err_sum[ERR_W-1:0];
                    if (c1) begin
                        cmd_next.x = cmd_reg.sx_pos ? cmd_reg.x + 1'b1 : cmd_reg.x - 1'b1;
                    end
                    if (c2) begin
                        cmd_next.y = cmd_reg.sy_pos ? cmd_reg.y + 1'b1 : cmd_reg.y - 1'b1;
                    end
                    if (last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        cnt_reg <= cnt_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        pc_reg  <= pc_next;
        pl_reg  <= pl_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_x    = px_reg;
    assign m_pixel_y    = py_reg;
    assign m_pixel_char = pc_reg;
    assign m_last_pixel = pl_reg;

endmodule

/* hw/rtl/line_rasterizer_core.sv */
// A line of N = max(|dx|,|dy|)+1 pixels (N <= 64) is drawn by the walker: it first loads the
// command from the queue, then emits one pixel per cycle from its error-update loop while
// the output is not stalled.
// Up to two further requests wait in the command queue while a line is drawn.
// Reset: synchronous, active low; clears the queue, the walker and the output valid.
module line_rasterizer_core #(
    parameter int CANVAS_SIZE = lr_pkg::DEF_CANVAS_SIZE
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [lr_pkg::COORD_W-1:0] s_start_x,
    input  logic [lr_pkg::COORD_W-1:0] s_start_y,
    input  logic [lr_pkg::COORD_W-1:0] s_end_x,
    input  logic [lr_pkg::COORD_W-1:0] s_end_y,
    input  logic [lr_pkg::CHAR_W-1:0]  s_fill_char,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lr_pkg::COORD_W-1:0] m_pixel_x,
    output logic [lr_pkg::COORD_W-1:0] m_pixel_y,
    output logic [lr_pkg::CHAR_W-1:0]  m_pixel_char,
    output logic                       m_last_pixel
);
    import lr_pkg::*;

    queue_stat_t q_stat;
    line_cmd_t   push_cmd, head_cmd;
    logic        q_push, q_pop;

    lr_front #(.CANVAS_SIZE(CANVAS_SIZE)) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_x   (s_start_x),
        .s_start_y   (s_start_y),
        .s_end_x     (s_end_x),
        .s_end_y     (s_end_y),
        .s_fill_char (s_fill_char),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    lr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    lr_walker u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_pixel_char (m_pixel_char),
        .m_last_pixel (m_last_pixel)
    );

endmodule

/* hw/rtl/lr_checker.sv */
module lr_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [lr_pkg::COORD_W-1:0] m_pixel_x,
    input logic [lr_pkg::COORD_W-1:0] m_pixel_y,
    input logic [lr_pkg::CHAR_W-1:0]  m_pixel_char,
    input logic                       m_last_pixel
);
    import lr_pkg::*;

    logic               in_line_reg;
    logic [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [CHAR_W-1:0]  prev_c_reg;
    logic               m_acc, step_ok;

    assign m_acc = m_valid && m_ready;
    assign step_ok = ((m_pixel_x - prev_x_reg) <= COORD_W'(1)
                      || (prev_x_reg - m_pixel_x) <= COORD_W'(1))
                  && ((m_pixel_y - prev_y_reg) <= COORD_W'(1)
                      || (prev_y_reg - m_pixel_y) <= COORD_W'(1))
                  && (m_pixel_char == prev_c_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_line_reg <= 1'b0;
        end else if (m_acc) begin
            in_line_reg <= !m_last_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_acc) begin
            prev_x_reg <= m_pixel_x;
            prev_y_reg <= m_pixel_y;
            prev_c_reg <= m_pixel_char;
        end
    end

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_pixel_x) && $stable(m_pixel_y)
            && $stable(m_pixel_char) && $stable(m_last_pixel))
        else $error("result payload changed while stalled");

    a_adjacent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc && in_line_reg |-> step_ok)
        else $error("consecutive pixels of one line are not adjacent");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_pixel_x    (m_pixel_x),
    .m_pixel_y    (m_pixel_y),
    .m_pixel_char (m_pixel_char),
    .m_last_pixel (m_last_pixel)
);

/* tb/sv/line_rasterizer_core_tb.sv */
`timescale 1ns / 100ps

module line_rasterizer_core_tb;

    import lr_pkg::*;

    localparam int CANVAS      = DEF_CANVAS_SIZE;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_RANDOM  = 188;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [CHAR_W-1:0]  fill_char;
    } line_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAR_W-1:0]  ch;
        logic               last;
    } pixel_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [COORD_W-1:0] s_start_x = '0;
    logic [COORD_W-1:0] s_start_y = '0;
    logic [COORD_W-1:0] s_end_x = '0;
    logic [COORD_W-1:0] s_end_y = '0;
    logic [CHAR_W-1:0]  s_fill_char = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [COORD_W-1:0] m_pixel_x;
    logic [COORD_W-1:0] m_pixel_y;
    logic [CHAR_W-1:0]  m_pixel_char;
    logic               m_last_pixel;

    line_req_t pending_lines[$];
    pixel_t    expected_pixels[$];
    line_req_t cur_line;
    pixel_t    got_pixel;

    int burst_left   = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int ready_phase  = 0;
    int lines_drawn  = 0;
    int pixels_seen  = 0;
    int mismatches   = 0;
    int cycle_count  = 0;

    line_rasterizer_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_x   (s_start_x),
        .s_start_y   (s_start_y),
        .s_end_x     (s_end_x),
        .s_end_y     (s_end_y),
        .s_fill_char (s_fill_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_x   (m_pixel_x),
        .m_pixel_y   (m_pixel_y),
        .m_pixel_char(m_pixel_char),
        .m_last_pixel(m_last_pixel)
    );

    always #2 aclk = ~aclk;

    function automatic int saturate(int c);
        if (c < 0) return 0;
        if (c > CANVAS - 1) return CANVAS - 1;
        return c;
    endfunction

    function automatic void rasterize_line(line_req_t r);
        pixel_t line_pixels[$];
        pixel_t p;
        int x, y, xe, ye, dx, dy, sx, sy, err, e2;
        x  = saturate(int'(r.start_x));
        y  = saturate(int'(r.start_y));
        xe = saturate(int'(r.end_x));
        ye = saturate(int'(r.end_y));
        dx = (xe > x) ? xe - x : x - xe;
        dy = -((ye > y) ? ye - y : y - ye);
        sx = (x < xe) ? 1 : -1;
        sy = (y < ye) ? 1 : -1;
        err = dx + dy;
        while (1) begin
            p.x    = COORD_W'(x);
            p.y    = COORD_W'(y);
            p.ch   = r.fill_char;
            p.last = 1'b0;
            line_pixels.push_back(p);
            if (line_pixels.size() >= MAX_PIXELS) break;
            if (x == xe && y == ye) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
                if (x == xe) break;
                err += dy;
                x += sx;
            end
            if (e2 <= dx) begin
                if (y == ye) break;
                err += dx;
                y += sy;
            end
        end
        line_pixels[line_pixels.size() - 1].last = 1'b1;
        foreach (line_pixels[i]) expected_pixels.push_back(line_pixels[i]);
    endfunction

    function automatic void add_line(int x0, int y0, int x1, int y1, int ch);
        line_req_t r;
        r.start_x   = COORD_W'(x0);
        r.start_y   = COORD_W'(y0);
        r.end_x     = COORD_W'(x1);
        r.end_y     = COORD_W'(y1);
        r.fill_char = CHAR_W'(ch);
        pending_lines.push_back(r);
    endfunction

    function automatic int near_coord(int c);
        return saturate(c + int'($urandom_range(0, 8)) - 4);
    endfunction

    function automatic int edge_coord();
        return ($urandom_range(0, 1) == 0) ? 0 : CANVAS - 1;
    endfunction

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // request driver: bursts of requests separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                rasterize_line(cur_line);
                lines_drawn++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_lines.size() > 0) begin
                    cur_line = pending_lines.pop_front();
                    s_start_x   <= cur_line.start_x;
                    s_start_y   <= cur_line.start_y;
                    s_end_x     <= cur_line.end_x;
                    s_end_y     <= cur_line.end_y;
                    s_fill_char <= cur_line.fill_char;
                    s_valid     <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            3:       gap_left = $urandom_range(10, 90);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_pixel = '{m_pixel_x, m_pixel_y, m_pixel_char, m_last_pixel};
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel x=%0d y=%0d char=%0d last=%0d",
                           got_pixel.x, got_pixel.y, got_pixel.ch, got_pixel.last);
                    mismatches++;
                end else begin
                    pixel_t want;
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", int'(want.x), int'(got_pixel.x));
                    check_field("pixel_y", int'(want.y), int'(got_pixel.y));
                    check_field("pixel_char", int'(want.ch), int'(got_pixel.ch));
                    check_field("last_pixel", int'(want.last), int'(got_pixel.last));
                    pixels_seen++;
                end
            end
            ready_phase = (ready_phase + 1) % 512;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (ready_phase >= 128 && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int kind, x0, y0;

        // single point, both corners
        add_line(0, 0, 0, 0, 8'h00);
        add_line(63, 63, 63, 63, 8'hFF);
        // full-length diagonals
        add_line(0, 0, 63, 63, 8'h55);
        add_line(63, 63, 0, 0, 8'hAA);
        add_line(0, 63, 63, 0, 8'h0F);
        add_line(63, 0, 0, 63, 8'hF0);
        // axis-aligned, both directions
        add_line(0, 10, 63, 10, 8'h2A);
        add_line(63, 20, 0, 20, 8'h23);
        add_line(5, 0, 5, 63, 8'h7C);
        add_line(40, 63, 40, 0, 8'h80);
        // one line per octant around the center
        add_line(32, 32, 60, 40, 8'h01);
        add_line(32, 32, 40, 60, 8'h02);
        add_line(32, 32, 24, 60, 8'h04);
        add_line(32, 32, 4, 40, 8'h08);
        add_line(32, 32, 4, 24, 8'h10);
        add_line(32, 32, 24, 4, 8'h20);
        add_line(32, 32, 40, 4, 8'h40);
        add_line(32, 32, 60, 24, 8'h7F);
        // shallowest and steepest full-span lines, neighbors
        add_line(0, 0, 63, 1, 8'hC3);
        add_line(0, 0, 1, 63, 8'h3C);
        add_line(10, 10, 11, 11, 8'h99);
        add_line(11, 10, 10, 11, 8'h66);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            kind = $urandom_range(0, 9);
            x0 = $urandom_range(0, CANVAS - 1);
            y0 = $urandom_range(0, CANVAS - 1);
            case (kind)
                0, 1, 2, 3: add_line(x0, y0, $urandom_range(0, CANVAS - 1),
                                     $urandom_range(0, CANVAS - 1), $urandom_range(0, 255));
                4, 5, 6:    add_line(x0, y0, near_coord(x0), near_coord(y0),
                                     $urandom_range(0, 255));
                7:          if ($urandom_range(0, 1) == 0)
                                add_line(x0, y0, $urandom_range(0, CANVAS - 1), y0,
                                         $urandom_range(0, 255));
                            else
                                add_line(x0, y0, x0, $urandom_range(0, CANVAS - 1),
                                         $urandom_range(0, 255));
                8:          add_line(x0, y0, x0, y0, $urandom_range(0, 255));
                default:    add_line(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                                     $urandom_range(0, 255));
            endcase
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (pending_lines.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Rasterized %0d lines (all octants, axis-aligned, single-point, edges)",
                 lines_drawn);
        $display("Checked %0d pixels under random request gaps and output stalls, %0d mismatches",
                 pixels_seen, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
